[hw/rtl/g2r_pkg.sv]
// g2r_pkg: shared types and constants for the 2bpp glyph row repacker
// used by g2r_front, g2r_queue, g2r_back and glyph_2bpp_row_repacker
// no dependencies
package g2r_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one decoded item: an optional full byte and an optional flushed partial byte
  typedef struct packed {
    logic       full_vld;
    logic [7:0] full_byte;
    logic       full_last;
    logic       flush_vld;
    logic [7:0] flush_byte;
  } g2r_cmd_t;

endpackage

[hw/rtl/g2r_front.sv]
// g2r_front: accepts source bytes, tracks row and glyph position, merges pixels
// with the pending ones and produces a command for the result queue
// depends on g2r_pkg
module g2r_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_src_byte,
  input  logic [7:0]         in_glyph_width,
  input  logic [7:0]         in_glyph_height,
  input  logic               q_full,
  output logic               q_push,
  output g2r_pkg::g2r_cmd_t  q_wdata
);
  import g2r_pkg::*;

  logic [5:0]  pend_bits_r, pend_bits_nxt;
  logic [1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [5:0]  byte_in_row_r, byte_in_row_nxt;
  logic [7:0]  row_index_r, row_index_nxt;

  logic        accept;
  logic        geom_ok;
  logic [6:0]  stride;
  logic        row_last;
  logic        glyph_last;
  logic [2:0]  npix;
  logic [7:0]  src_masked;
  logic [5:0]  pend_left;
  logic [13:0] seq;
  logic [2:0]  total;
  logic        full;
  logic [1:0]  rc;
  logic [5:0]  rsrc;
  logic [5:0]  rem_right;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign geom_ok  = (in_glyph_width != 8'd0) && (in_glyph_height != 8'd0);

  assign stride     = {1'b0, in_glyph_width[7:2]} + 7'(in_glyph_width[1:0] != 2'd0);
  assign row_last   = ({1'b0, byte_in_row_r} + 7'd1) >= stride;
  assign glyph_last = row_last &&
                      (({1'b0, row_index_r} + 9'd1) >= {1'b0, in_glyph_height});

  always_comb begin
    npix = 3'd4;
    if (row_last && (in_glyph_width[1:0] != 2'd0)) begin
      npix = {1'b0, in_glyph_width[1:0]};
    end
    case (npix)
      3'd1:    src_masked = in_src_byte & 8'hC0;
      3'd2:    src_masked = in_src_byte & 8'hF0;
      3'd3:    src_masked = in_src_byte & 8'hFC;
      default: src_masked = in_src_byte;
    endcase
    case (pend_cnt_r)
      2'd0:    pend_left = 6'd0;
      2'd1:    pend_left = {pend_bits_r[1:0], 4'd0};
      2'd2:    pend_left = {pend_bits_r[3:0], 2'd0};
      default: pend_left = pend_bits_r;
    endcase
  end

  // pixels left-aligned: pending ones first, then the new ones
  assign seq   = {pend_left, 8'd0} | ({src_masked, 6'd0} >> {pend_cnt_r, 1'b0});
  assign total = {1'b0, pend_cnt_r} + npix;
  assign full  = total[2];
  assign rc    = total[1:0];
  assign rsrc  = full ? seq[5:0] : seq[13:8];

  always_comb begin
    case (rc)
      2'd0:    rem_right = 6'd0;
      2'd1:    rem_right = {4'd0, rsrc[5:4]};
      2'd2:    rem_right = {2'd0, rsrc[5:2]};
      default: rem_right = rsrc;
    endcase
  end

  always_comb begin
    q_wdata.full_vld   = full;
    q_wdata.full_byte  = seq[13:6];
    q_wdata.full_last  = glyph_last && (rc == 2'd0);
    q_wdata.flush_vld  = glyph_last && (rc != 2'd0);
    q_wdata.flush_byte = {rsrc, 2'd0};
    q_push = accept && geom_ok && (full || (glyph_last && (rc != 2'd0)));

    pend_bits_nxt   = pend_bits_r;
    pend_cnt_nxt    = pend_cnt_r;
    byte_in_row_nxt = byte_in_row_r;
    row_index_nxt   = row_index_r;
    if (accept && geom_ok) begin
      if (glyph_last) begin
        pend_bits_nxt   = 6'd0;
        pend_cnt_nxt    = 2'd0;
        byte_in_row_nxt = 6'd0;
        row_index_nxt   = 8'd0;
      end else begin
        pend_bits_nxt = rem_right;
        pend_cnt_nxt  = rc;
        if (row_last) begin
          byte_in_row_nxt = 6'd0;
          row_index_nxt   = row_index_r + 8'd1;
        end else begin
          byte_in_row_nxt = byte_in_row_r + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r   <= 6'd0;
      pend_cnt_r    <= 2'd0;
      byte_in_row_r <= 6'd0;
      row_index_r   <= 8'd0;
    end else begin
      pend_bits_r   <= pend_bits_nxt;
      pend_cnt_r    <= pend_cnt_nxt;
      byte_in_row_r <= byte_in_row_nxt;
      row_index_r   <= row_index_nxt;
    end
  end

endmodule

[hw/rtl/g2r_queue.sv]
// g2r_queue: small command queue between the front and back parts
// depends on g2r_pkg
module g2r_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  g2r_pkg::g2r_cmd_t  wdata,
  output logic               full,
  input  logic               pop,
  output g2r_pkg::g2r_cmd_t  rdata,
  output logic               empty
);
  import g2r_pkg::*;

  g2r_cmd_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = wptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = rptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/g2r_back.sv]
// g2r_back: takes commands from the queue and delivers their packed bytes one at a time
// on the result channel, full byte first, then any flushed partial byte
// depends on g2r_pkg
module g2r_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  g2r_pkg::g2r_cmd_t  q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_packed_byte,
  output logic               out_glyph_done
);
  import g2r_pkg::*;

  g2r_cmd_t cur_r, cur_nxt;
  logic     cur_vld_r, cur_vld_nxt;
  logic     phase_r, phase_nxt;

  logic     show_flush;
  logic     cmd_done;
  logic     fire;
  logic     load;

  assign show_flush      = phase_r || !cur_r.full_vld;
  assign cmd_done        = show_flush || !cur_r.flush_vld;
  assign out_valid       = cur_vld_r;
  assign out_packed_byte = show_flush ? cur_r.flush_byte : cur_r.full_byte;
  assign out_glyph_done  = show_flush ? 1'b1 : cur_r.full_last;
  assign fire            = cur_vld_r && out_ready;
  assign load            = !cur_vld_r || (fire && cmd_done);
  assign q_pop           = load && !q_empty;

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    phase_nxt   = phase_r;
    if (load) begin
      cur_nxt     = q_rdata;
      cur_vld_nxt = !q_empty;
      phase_nxt   = 1'b0;
    end else if (fire) begin
      phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      phase_r   <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      phase_r   <= phase_nxt;
    end
  end

  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_cmd_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (cur_r.full_vld || cur_r.flush_vld))
    else $error("held command carries no byte");

  a_phase_two_part : assert property (@(posedge clk) disable iff (!rst_n)
    (cur_vld_r && phase_r) |-> (cur_r.full_vld && cur_r.flush_vld))
    else $error("second phase on a single-byte command");

  a_second_after_first : assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !cmd_done) |=> (cur_vld_r && phase_r && $stable(cur_r)))
    else $error("flush byte not delivered after full byte");

endmodule

[hw/rtl/glyph_2bpp_row_repacker.sv]
// glyph_2bpp_row_repacker: strips the row padding from 2bpp glyph bitmaps and
// emits a continuous MSB-first packed byte stream
// depends on g2r_pkg, g2r_front, g2r_queue, g2r_back
//
// one source byte is taken per cycle while the four-entry command queue has room;
// each byte is classified and merged with pending pixels in the same cycle; its
// command is queued, then loaded into the back part's register before its bytes
// reach the output. while out_ready is high, the output delivers one packed byte
// per cycle, so the rate is one item per cycle except at glyph end, where a full
// and a flushed partial byte go out in turn. a zero width or height drops the item.
module glyph_2bpp_row_repacker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_src_byte,
  input  logic [7:0] in_glyph_width,
  input  logic [7:0] in_glyph_height,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_packed_byte,
  output logic       out_glyph_done
);
  import g2r_pkg::*;

  g2r_cmd_t q_wdata;
  g2r_cmd_t q_rdata;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  g2r_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_src_byte     (in_src_byte),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  g2r_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  g2r_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_byte (out_packed_byte),
    .out_glyph_done  (out_glyph_done)
  );

endmodule

[sim/glyph_2bpp_row_repacker_tb.sv]
// glyph_2bpp_row_repacker_tb: drives glyph bitmaps through the 2bpp row repacker and
// checks every packed byte and its glyph_done flag against a predictor held in the tb
// depends on glyph_2bpp_row_repacker only
module glyph_2bpp_row_repacker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_src_byte = 8'h00;
  logic [7:0] in_glyph_width = 8'h00;
  logic [7:0] in_glyph_height = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_packed_byte;
  logic       out_glyph_done;

  int items_sent = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  int out_stall_left = 0;

  typedef struct {
    logic [7:0] pix_byte;
    logic       last;
  } packed_out_t;

  class glyph_pack_scoreboard;
    logic [5:0]  pend_bits;
    logic [2:0]  pend_cnt;
    logic [5:0]  col_byte;
    logic [7:0]  row_idx;
    packed_out_t packed_expect_q[$];
    int          errors;

    function new();
      errors = 0;
      clear_glyph();
    endfunction

    function void clear_glyph();
      pend_bits = '0;
      pend_cnt = '0;
      col_byte = '0;
      row_idx = '0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void push_byte(logic [7:0] b, logic last);
      packed_out_t e;
      e.pix_byte = b;
      e.last = last;
      packed_expect_q.push_back(e);
    endfunction

    function void note_source_byte(logic [7:0] src, logic [7:0] w, logic [7:0] h);
      int         stride;
      int         npix;
      int         cnt;
      logic [7:0] acc;
      logic [1:0] px;
      bit         row_last;
      bit         glyph_last;
      bit         full_pushed;
      if (w == 8'd0 || h == 8'd0) return;
      full_pushed = 1'b0;
      stride = (int'(w) + 3) / 4;
      row_last = (int'(col_byte) + 1 >= stride);
      glyph_last = row_last && (int'(row_idx) + 1 >= int'(h));
      npix = (row_last && w[1:0] != 2'd0) ? int'(w[1:0]) : 4;
      acc = {2'b00, pend_bits};
      cnt = int'(pend_cnt);
      for (int i = 0; i < npix; i++) begin
        px = 2'((src >> (6 - 2 * i)) & 8'h03);
        acc = {acc[5:0], px};
        cnt++;
        if (cnt == 4) begin
          push_byte(acc, 1'b0);
          full_pushed = 1'b1;
          acc = '0;
          cnt = 0;
        end
      end
      if (glyph_last) begin
        if (cnt > 0)
          push_byte(8'(acc << (8 - 2 * cnt)), 1'b1);
        else if (full_pushed)
          packed_expect_q[packed_expect_q.size() - 1].last = 1'b1;
        clear_glyph();
        return;
      end
      pend_bits = acc[5:0];
      pend_cnt = 3'(cnt);
      if (row_last) begin
        col_byte = '0;
        row_idx = row_idx + 8'd1;
      end else begin
        col_byte = col_byte + 6'd1;
      end
    endfunction

    task check_packed_byte(logic [7:0] b, logic done);
      packed_out_t e;
      if (packed_expect_q.size() == 0) begin
        report($sformatf("unexpected byte %02h done %0b", b, done));
        return;
      end
      e = packed_expect_q.pop_front();
      if (b !== e.pix_byte)
        report($sformatf("packed_byte %02h, expected %02h", b, e.pix_byte));
      if (done !== e.last)
        report($sformatf("glyph_done %0b, expected %0b (byte %02h)", done, e.last, b));
    endtask
  endclass

  glyph_pack_scoreboard sb = new();

  glyph_2bpp_row_repacker DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_src_byte(in_src_byte),
    .in_glyph_width(in_glyph_width),
    .in_glyph_height(in_glyph_height),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_packed_byte(out_packed_byte),
    .out_glyph_done(out_glyph_done)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_ready = 1'b0;
      out_stall_left--;
    end else begin
      out_ready = 1'b1;
      if (out_idle_on) out_stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_packed_byte(out_packed_byte, out_glyph_done);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [7:0] src, input logic [7:0] w, input logic [7:0] h);
    int gap;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_src_byte = src;
    in_glyph_width = w;
    in_glyph_height = h;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_source_byte(src, w, h);
    if (w != 8'd0 && h != 8'd0) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_glyph(input logic [7:0] w, input logic [7:0] h);
    int nbytes;
    nbytes = ((int'(w) + 3) / 4) * int'(h);
    for (int i = 0; i < nbytes; i++)
      send_item(8'($urandom), w, h);
  endtask

  task automatic pick_geometry(output logic [7:0] w, output logic [7:0] h);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      w = 8'($urandom_range(1, 24));
      h = 8'($urandom_range(1, 4));
    end else if (r < 90) begin
      w = 8'($urandom_range(1, 64));
      h = 8'($urandom_range(1, 8));
    end else if (r < 98) begin
      w = 8'($urandom_range(200, 255));
      h = 8'($urandom_range(1, 2));
    end else begin
      w = 8'($urandom_range(1, 4));
      h = 8'($urandom_range(200, 255));
    end
  endtask

  // a 1x1 glyph always closes whatever glyph is in progress
  task automatic broken_glyph();
    logic [7:0] w;
    logic [7:0] h;
    int         n;
    pick_geometry(w, h);
    n = $urandom_range(1, ((int'(w) + 3) / 4) * int'(h));
    for (int i = 0; i < n; i++)
      send_item(8'($urandom), w, h);
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      w = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
      h = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
      send_item(8'($urandom), w, h);
    end
    send_item(8'($urandom), 8'd1, 8'd1);
  endtask

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [7:0] w;
    logic [7:0] h;
    int         r;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero geometry is dropped
    send_item(8'hA5, 8'd0, 8'd5);
    send_item(8'h5A, 8'd7, 8'd0);
    // single pixel flush, single full byte
    send_item(8'hFF, 8'd1, 8'd1);
    send_item(8'hE4, 8'd4, 8'd1);
    // full byte and flush together on the last item
    send_item(8'h1B, 8'd7, 8'd2);
    send_item(8'hE4, 8'd7, 8'd2);
    send_item(8'h00, 8'd7, 8'd2);
    send_item(8'hFF, 8'd7, 8'd2);
    send_glyph(8'd3, 8'd3);
    // geometry shrinks mid glyph, a position past the new bounds ends the row and the glyph
    send_item(8'h11, 8'd12, 8'd3);
    send_item(8'h22, 8'd12, 8'd3);
    send_item(8'h33, 8'd4, 8'd3);
    send_item(8'h44, 8'd4, 8'd1);
    // widest and tallest, then closed by a 1x1
    send_item(8'h96, 8'd255, 8'd255);
    send_item(8'h69, 8'd1, 8'd1);

    while (items_sent < 820) begin
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 82) begin
        pick_geometry(w, h);
        send_glyph(w, h);
      end else begin
        broken_glyph();
      end
    end
    in_valid = 1'b0;

    while (sb.packed_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
